/* rtl/low_quality_window_tagger_defines.svh */
// ----------------------------------------------------------------------------
// Low-quality window tagger assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LOW_QUALITY_WINDOW_TAGGER_DEFINES_SVH
`define LOW_QUALITY_WINDOW_TAGGER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LQWT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LQWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lqwt_pkg.sv */
// ----------------------------------------------------------------------------
// Low-quality window tagger package
// Widths, register map and result type shared by the tagger.
// ----------------------------------------------------------------------------
`default_nettype none

package lqwt_pkg;

  localparam int QUAL_BITS   = 8;
  localparam int POS_BITS    = 24;
  localparam int CONTIG_BITS = 16;
  localparam int COUNT_BITS  = 20;
  localparam int GAP_BITS    = 16;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [QUAL_BITS-1:0] THRESHOLD_RESET = QUAL_BITS'(45);
  localparam logic [GAP_BITS-1:0]  MERGE_GAP_RESET = GAP_BITS'(12);
  localparam logic [POS_BITS-1:0]  POS_MAX         = {POS_BITS{1'b1}};
  localparam logic [GAP_BITS-1:0]  GAP_MAX         = {GAP_BITS{1'b1}};

  typedef enum logic [1:0] {
    REG_GOOD_THRESHOLD = 2'd0,
    REG_MERGE_GAP      = 2'd1,
    REG_KEEP_EDGE      = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CONTIG_BITS-1:0] contig_index;
    logic [POS_BITS-1:0]    window_begin;
    logic [POS_BITS-1:0]    window_end;
    logic [COUNT_BITS-1:0]  window_number;
  } window_t;

endpackage

`default_nettype wire

/* rtl/low_quality_window_tagger.sv */
// ----------------------------------------------------------------------------
// Low-quality window tagger
// Finds runs of low-quality bases per contig, merges close runs and reports
// each finished window with its contig index and running window number.
// ----------------------------------------------------------------------------
// Usage: one base quality request arrives on the in_ channel per cycle, with
// in_contig_last on the final base of each contig and in_new_batch to restart
// contig and window numbering. Each request is accepted when in_valid is high
// and in_stall is low, and produces zero or one window on the out_ channel.
// A closed window enters the output register, or the skid register if that is
// full. The block takes one base every cycle; the only limit is the two-entry
// output buffer (output register plus skid register), so in_stall rises only
// once both entries hold untaken windows. While out_stall is high the presented
// window holds steady. Thresholds must be written through the APB-style port
// while the stream is idle; the block does not enforce it. Synchronous reset
// empties the output buffer, clears counters and positions except held window
// bounds and restores the defaults (threshold 45, merge gap 12, keep edges on).
// ----------------------------------------------------------------------------
`default_nettype none

module low_quality_window_tagger (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [lqwt_pkg::QUAL_BITS-1:0]   in_quality,
  input  wire logic                             in_contig_last,
  input  wire logic                             in_new_batch,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [lqwt_pkg::CONTIG_BITS-1:0]      out_contig_index,
  output logic [lqwt_pkg::POS_BITS-1:0]         out_window_begin,
  output logic [lqwt_pkg::POS_BITS-1:0]         out_window_end,
  output logic [lqwt_pkg::COUNT_BITS-1:0]       out_window_number,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lqwt_pkg::ADDR_BITS-1:0]   paddr,
  input  wire logic [lqwt_pkg::DATA_BITS-1:0]   pwdata,
  output logic [lqwt_pkg::DATA_BITS-1:0]        prdata,
  output logic                                  pready
);

  import lqwt_pkg::*;

  `include "low_quality_window_tagger_defines.svh"

  logic [QUAL_BITS-1:0]   threshold_r;
  logic [GAP_BITS-1:0]    merge_gap_r;
  logic                   keep_edge_r;

  logic [POS_BITS-1:0]    position_r,    position_nxt;
  logic                   in_bad_r,      in_bad_nxt;
  logic [POS_BITS-1:0]    run_start_r,   run_start_nxt;
  logic                   pend_valid_r,  pend_valid_nxt;
  logic [POS_BITS-1:0]    pend_begin_r,  pend_begin_nxt;
  logic [POS_BITS-1:0]    pend_end_r,    pend_end_nxt;
  logic [GAP_BITS-1:0]    good_len_r,    good_len_nxt;
  logic [CONTIG_BITS-1:0] contig_r,      contig_nxt;
  logic [COUNT_BITS-1:0]  win_count_r,   win_count_nxt;

  logic                   out_valid_r,   skid_valid_r;
  window_t                out_data_r,    skid_data_r;

  logic                   accept;
  logic                   pop;
  logic                   produce;
  window_t                result;

  reg_idx_t               wr_idx;
  logic                   cfg_write;

  logic [POS_BITS-1:0]    pos_b;
  logic                   in_bad_b;
  logic [POS_BITS-1:0]    run_start_b;
  logic                   pend_valid_b;
  logic [GAP_BITS-1:0]    good_len_b;
  logic [CONTIG_BITS-1:0] contig_b;
  logic [COUNT_BITS-1:0]  win_count_b;
  logic [POS_BITS-1:0]    len;
  logic                   is_bad;
  logic                   give;
  logic [POS_BITS-1:0]    give_begin;
  logic [POS_BITS-1:0]    give_end;
  logic [GAP_BITS-1:0]    good_inc;

  // Configuration port.
  assign pready    = 1'b1;
  assign wr_idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      merge_gap_r <= MERGE_GAP_RESET;
      keep_edge_r <= 1'b1;
    end else if (cfg_write) begin
      case (wr_idx)
        REG_GOOD_THRESHOLD: threshold_r <= pwdata[QUAL_BITS-1:0];
        REG_MERGE_GAP:      merge_gap_r <= pwdata[GAP_BITS-1:0];
        REG_KEEP_EDGE:      keep_edge_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (wr_idx)
      REG_GOOD_THRESHOLD: prdata = DATA_BITS'(threshold_r);
      REG_MERGE_GAP:      prdata = DATA_BITS'(merge_gap_r);
      REG_KEEP_EDGE:      prdata = DATA_BITS'(keep_edge_r);
      default:            prdata = '0;
    endcase
  end

  // Window tracking for the base being accepted.
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign pop      = out_valid_r && !out_stall;

  always_comb begin
    pos_b        = in_new_batch ? '0 : position_r;
    in_bad_b     = in_new_batch ? 1'b0 : in_bad_r;
    run_start_b  = in_new_batch ? '0 : run_start_r;
    pend_valid_b = in_new_batch ? 1'b0 : pend_valid_r;
    good_len_b   = in_new_batch ? '0 : good_len_r;
    contig_b     = in_new_batch ? '0 : contig_r;
    win_count_b  = in_new_batch ? '0 : win_count_r;

    len    = (pos_b == POS_MAX) ? pos_b : pos_b + POS_BITS'(1);
    is_bad = in_quality < threshold_r;

    position_nxt   = len;
    in_bad_nxt     = in_bad_b;
    run_start_nxt  = run_start_b;
    pend_valid_nxt = pend_valid_b;
    pend_begin_nxt = pend_begin_r;
    pend_end_nxt   = pend_end_r;
    good_len_nxt   = good_len_b;
    contig_nxt     = contig_b;
    good_inc       = good_len_b;
    give           = 1'b0;
    give_begin     = run_start_b;
    give_end       = len;

    if (is_bad) begin
      if (!in_bad_b) begin
        run_start_nxt  = pend_valid_b ? pend_begin_r : pos_b;
        pend_valid_nxt = 1'b0;
        in_bad_nxt     = 1'b1;
      end
      if (in_contig_last) begin
        give       = 1'b1;
        give_begin = run_start_nxt;
        give_end   = len;
        in_bad_nxt = 1'b0;
      end
    end else begin
      if (in_bad_b) begin
        pend_begin_nxt = run_start_b;
        pend_end_nxt   = pos_b;
        pend_valid_nxt = 1'b1;
        good_len_nxt   = '0;
        in_bad_nxt     = 1'b0;
      end
      if (pend_valid_nxt) begin
        good_inc     = (good_len_nxt == GAP_MAX) ? good_len_nxt
                                                 : good_len_nxt + GAP_BITS'(1);
        good_len_nxt = good_inc;
        if (good_inc >= merge_gap_r || in_contig_last) begin
          give           = 1'b1;
          give_begin     = pend_begin_nxt;
          give_end       = pend_end_nxt;
          pend_valid_nxt = 1'b0;
        end
      end
    end

    produce = give && (keep_edge_r || (give_begin != '0 && give_end != len));
    win_count_nxt = produce ? win_count_b + COUNT_BITS'(1) : win_count_b;

    result.contig_index  = contig_b;
    result.window_begin  = give_begin;
    result.window_end    = give_end;
    result.window_number = win_count_b;

    if (in_contig_last) begin
      position_nxt   = '0;
      in_bad_nxt     = 1'b0;
      run_start_nxt  = '0;
      pend_valid_nxt = 1'b0;
      good_len_nxt   = '0;
      contig_nxt     = contig_b + CONTIG_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      in_bad_r     <= 1'b0;
      run_start_r  <= '0;
      pend_valid_r <= 1'b0;
      good_len_r   <= '0;
      contig_r     <= '0;
      win_count_r  <= '0;
    end else if (accept) begin
      position_r   <= position_nxt;
      in_bad_r     <= in_bad_nxt;
      run_start_r  <= run_start_nxt;
      pend_valid_r <= pend_valid_nxt;
      good_len_r   <= good_len_nxt;
      contig_r     <= contig_nxt;
      win_count_r  <= win_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_begin_r <= pend_begin_nxt;
      pend_end_r   <= pend_end_nxt;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_r <= accept && produce;
    end else if (accept && produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (!out_valid_r || pop) begin
      out_data_r <= result;
    end else begin
      skid_data_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_contig_index  = out_data_r.contig_index;
  assign out_window_begin  = out_data_r.window_begin;
  assign out_window_end    = out_data_r.window_end;
  assign out_window_number = out_data_r.window_number;

  `LQWT_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full with output empty")
  `LQWT_ASSERT_SAME(a_run_or_pending, 1'b1, !(in_bad_r && pend_valid_r), "open and held window")
  `LQWT_ASSERT_NEXT(a_skid_drains, skid_valid_r && !out_stall, !skid_valid_r, "skid not drained")

endmodule

`default_nettype wire
